[hw/rtl/hrm_pkg.sv]
// Package for the histogram running median: payload types, defaults, controller interface.
`default_nettype none
package hrm_pkg;

  // Default configuration handed to the top level parameters
  localparam int SAMPLE_BITS_DEF = 8;
  localparam int MAX_SAMPLES_DEF = 1024;

  // Input transfer payload
  typedef struct packed {
    logic       add_valid;
    logic [7:0] add_sample;
    logic       drop_valid;
    logic [7:0] drop_sample;
  } in_t;

  // Result transfer payload
  typedef struct packed {
    logic [7:0]  median_value;
    logic        window_empty;
    logic [10:0] sample_count;
    logic        drop_missing;
    logic        add_overflow;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // latch a new input item
    logic clr_wr;    // write zero at the clear address, advance it
    logic drop_rd;   // read the bin to remove from
    logic drop_upd;  // apply the removal from read data
    logic add_rd;    // read the bin to insert into
    logic add_upd;   // apply the insert from read data
    logic add_ovf;   // flag an insert refused on a full window
    logic fwd_rd;    // read the bin under the median pointer
    logic fwd_step;  // absorb read bin into count below, advance pointer
    logic bwd_rd;    // step pointer back and read that bin
    logic bwd_step;  // remove read bin from count below
    logic finish;    // capture the result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;   // clear sweep is at its last bin
    logic drop_req;   // item removes a sample
    logic add_req;    // item inserts a sample
    logic add_ok;     // window has room
    logic empty;      // window holds no samples
    logic fwd_dir;    // pointer is at or below the target rank
    logic fwd_end;    // pointer sits on the last bin
    logic fwd_stop;   // read bin holds the target rank
    logic bwd_stop;   // backward walk is done
  } sts_t;

endpackage
`default_nettype wire

[hw/rtl/histogram_running_median.sv]
// Throughput: one item at a time; the next start is taken in the cycle of the one-cycle
// out_valid strobe, which the receiver cannot stall. Walk steps pace the single read port.
// Reset: a synchronous clear sweep zeroes all 2^SAMPLE_BITS bins, busy held high.
// Top level of the histogram running median.
`default_nettype none
module histogram_running_median #(
  parameter int SAMPLE_BITS = hrm_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_SAMPLES = hrm_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire hrm_pkg::in_t in_data,
  output logic              out_valid,
  output hrm_pkg::out_t     out_data
);

  hrm_pkg::cmd_t cmd;
  hrm_pkg::sts_t sts;

  hrm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  hrm_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

[hw/rtl/hrm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module hrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

[hw/rtl/hrm_datapath.sv]
// Datapath: bin count memory, median pointer, running counts and result register.
`default_nettype none
module hrm_datapath #(
  parameter int SAMPLE_BITS = hrm_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_SAMPLES = hrm_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire hrm_pkg::in_t in_data,
  input  wire hrm_pkg::cmd_t cmd,
  output hrm_pkg::sts_t     sts,
  output hrm_pkg::out_t     out_data
);

  localparam int BIN_W    = SAMPLE_BITS;
  localparam int NUM_BINS = 1 << SAMPLE_BITS;
  localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);

  hrm_pkg::in_t     in_r;
  hrm_pkg::out_t    out_r;
  logic [BIN_W-1:0] clr_addr_r;
  logic [BIN_W-1:0] median_r;
  logic [CNT_W-1:0] below_r;
  logic [CNT_W-1:0] total_r;
  logic             missing_r;
  logic             overflow_r;

  logic [BIN_W-1:0] drop_bin;
  logic [BIN_W-1:0] add_bin;
  logic [BIN_W-1:0] median_dec;
  logic [CNT_W-1:0] half;
  logic [CNT_W:0]   fwd_sum;
  logic [CNT_W-1:0] rd_data;
  logic [BIN_W-1:0] rd_addr;
  logic             wr_en;
  logic [BIN_W-1:0] wr_addr;
  logic [CNT_W-1:0] wr_data;

  assign drop_bin   = BIN_W'(in_r.drop_sample);
  assign add_bin    = BIN_W'(in_r.add_sample);
  assign median_dec = median_r - BIN_W'(1);
  // rank of the lower median; only used when the window is not empty
  assign half       = (total_r - CNT_W'(1)) >> 1;
  assign fwd_sum    = {1'b0, below_r} + {1'b0, rd_data};

  // Memory port steering
  always_comb begin
    rd_addr = median_r;
    if (cmd.drop_rd) begin
      rd_addr = drop_bin;
    end else if (cmd.add_rd) begin
      rd_addr = add_bin;
    end else if (cmd.bwd_rd) begin
      rd_addr = median_dec;
    end else if (cmd.fwd_rd) begin
      rd_addr = median_r;
    end
  end

  always_comb begin
    wr_en   = cmd.clr_wr | (cmd.drop_upd & (rd_data != '0)) | cmd.add_upd;
    wr_addr = clr_addr_r;
    wr_data = '0;
    if (cmd.drop_upd) begin
      wr_addr = drop_bin;
      wr_data = rd_data - CNT_W'(1);
    end else if (cmd.add_upd) begin
      wr_addr = add_bin;
      wr_data = rd_data + CNT_W'(1);
    end
  end

  hrm_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Status back to the controller
  always_comb begin
    sts.clr_last = &clr_addr_r;
    sts.drop_req = in_r.drop_valid;
    sts.add_req  = in_r.add_valid;
    sts.add_ok   = total_r < CNT_W'(MAX_SAMPLES);
    sts.empty    = total_r == '0;
    sts.fwd_dir  = half >= below_r;
    sts.fwd_end  = &median_r;
    sts.fwd_stop = fwd_sum > {1'b0, half};
    sts.bwd_stop = (below_r <= half) || (median_r == '0);
  end

  // Item registers and result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_data;
    end
    if (cmd.finish) begin
      out_r.median_value <= (total_r == '0) ? 8'd0 : 8'(median_r);
      out_r.window_empty <= total_r == '0;
      out_r.sample_count <= 11'(total_r);
      out_r.drop_missing <= missing_r;
      out_r.add_overflow <= overflow_r;
    end
  end

  // Window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      median_r   <= '0;
      below_r    <= '0;
      total_r    <= '0;
      missing_r  <= 1'b0;
      overflow_r <= 1'b0;
    end else begin
      if (cmd.clr_wr) begin
        clr_addr_r <= clr_addr_r + BIN_W'(1);
      end
      if (cmd.load) begin
        missing_r  <= 1'b0;
        overflow_r <= 1'b0;
      end
      if (cmd.drop_upd) begin
        if (rd_data == '0) begin
          missing_r <= 1'b1;
        end else begin
          total_r <= total_r - CNT_W'(1);
          if (drop_bin < median_r) begin
            below_r <= below_r - CNT_W'(1);
          end
        end
      end
      if (cmd.add_ovf) begin
        overflow_r <= 1'b1;
      end
      if (cmd.add_upd) begin
        total_r <= total_r + CNT_W'(1);
        if (add_bin < median_r) begin
          below_r <= below_r + CNT_W'(1);
        end
      end
      if (cmd.fwd_step) begin
        below_r  <= CNT_W'(fwd_sum);
        median_r <= median_r + BIN_W'(1);
      end
      if (cmd.bwd_rd) begin
        median_r <= median_dec;
      end
      if (cmd.bwd_step) begin
        below_r <= below_r - rd_data;
      end
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

[hw/rtl/hrm_ctrl.sv]
// Controller: sequences clear sweep, removal, insert and median walk.
`default_nettype none
module hrm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  output logic               out_valid,
  input  wire hrm_pkg::sts_t sts,
  output hrm_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DROP,
    S_DROP_UPD,
    S_ADD,
    S_ADD_UPD,
    S_WALK,
    S_FWD,
    S_FWD_EV,
    S_BWD,
    S_BWD_EV
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DROP;
        end
      end
      S_DROP: begin
        if (sts.drop_req) begin
          cmd.drop_rd = 1'b1;
          state_nxt   = S_DROP_UPD;
        end else begin
          state_nxt = S_ADD;
        end
      end
      S_DROP_UPD: begin
        cmd.drop_upd = 1'b1;
        state_nxt    = S_ADD;
      end
      S_ADD: begin
        if (sts.add_req && sts.add_ok) begin
          cmd.add_rd = 1'b1;
          state_nxt  = S_ADD_UPD;
        end else begin
          cmd.add_ovf = sts.add_req;
          state_nxt   = S_WALK;
        end
      end
      S_ADD_UPD: begin
        cmd.add_upd = 1'b1;
        state_nxt   = S_WALK;
      end
      S_WALK: begin
        if (sts.empty) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (sts.fwd_dir) begin
          state_nxt = S_FWD;
        end else begin
          state_nxt = S_BWD;
        end
      end
      // forward walk: read the pointer's bin, then advance past it or stop
      S_FWD: begin
        if (sts.fwd_end) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.fwd_rd = 1'b1;
          state_nxt  = S_FWD_EV;
        end
      end
      S_FWD_EV: begin
        if (sts.fwd_stop) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.fwd_step = 1'b1;
          state_nxt    = S_FWD;
        end
      end
      // backward walk: step back, read, drop that bin from the count below
      S_BWD: begin
        if (sts.bwd_stop) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.bwd_rd = 1'b1;
          state_nxt  = S_BWD_EV;
        end
      end
      S_BWD_EV: begin
        cmd.bwd_step = 1'b1;
        state_nxt    = S_BWD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

[bench/histogram_running_median_test.sv]
// Self-checking histogram running median bench: directed, sliding windows, capacity, noise.
`timescale 1ns / 1ps
module histogram_running_median_test;

  localparam int WINDOW_CAP  = hrm_pkg::MAX_SAMPLES_DEF;
  localparam int NUM_BINS    = 1 << hrm_pkg::SAMPLE_BITS_DEF;
  // covers the worst item, a walk over the whole bin range, and the reset sweep
  localparam int STALL_LIMIT = 3000;
  localparam int MAX_PRINTS  = 30;

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  hrm_pkg::in_t  in_data;
  logic          out_valid;
  hrm_pkg::out_t out_data;

  histogram_running_median u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Predicted histogram state
  int hist_bins [NUM_BINS];
  int med_ptr;
  int below_cnt;
  int held_cnt;

  // Expected results, oldest first, and the sample multiset the stimulus believes is held
  hrm_pkg::out_t expected_results [$];
  logic [7:0]    window_fifo [$];

  int  error_count;
  int  items_accepted;
  int  results_seen;
  int  peak_window;
  int  drop_miss_cnt;
  int  overflow_cnt;
  int  empty_cnt;
  int  stall_cycles;
  bit  idle_enable;
  int  sample_center;
  int  sample_spread;

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Apply one item to the predicted histogram and walk the pointer to the lower median
  task automatic update_median(input hrm_pkg::in_t item, output hrm_pkg::out_t res);
    int rank;
    int c;
    res = '0;
    if (item.drop_valid) begin
      if (hist_bins[item.drop_sample] == 0) begin
        res.drop_missing = 1'b1;
      end else begin
        hist_bins[item.drop_sample]--;
        if (int'(item.drop_sample) < med_ptr) below_cnt--;
        held_cnt--;
      end
    end
    if (item.add_valid) begin
      if (held_cnt >= WINDOW_CAP) begin
        res.add_overflow = 1'b1;
      end else begin
        hist_bins[item.add_sample]++;
        if (int'(item.add_sample) < med_ptr) below_cnt++;
        held_cnt++;
      end
    end
    res.window_empty = (held_cnt == 0);
    res.sample_count = held_cnt[10:0];
    if (held_cnt != 0) begin
      rank = (held_cnt - 1) / 2 - below_cnt;
      if (rank >= 0) begin
        // forward: absorb bins that lie wholly below the target rank
        while (med_ptr < NUM_BINS - 1 && hist_bins[med_ptr] <= rank) begin
          c = hist_bins[med_ptr];
          below_cnt += c;
          rank -= c;
          med_ptr++;
        end
      end else begin
        while (rank < 0 && med_ptr > 0) begin
          med_ptr--;
          c = hist_bins[med_ptr];
          below_cnt -= c;
          rank += c;
        end
      end
      res.median_value = med_ptr[7:0];
    end
  endtask

  // Result check first, then the new transfer, so a same-edge start queues behind
  always @(posedge clk) begin : result_check
    hrm_pkg::out_t want;
    hrm_pkg::out_t pred;
    if (!rst_n) begin
      foreach (hist_bins[b]) hist_bins[b] = 0;
      med_ptr   = 0;
      below_cnt = 0;
      held_cnt  = 0;
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = expected_results.pop_front();
          if (out_data.median_value !== want.median_value)
            report_mismatch($sformatf("result %0d median_value got %0d expected %0d",
                                      results_seen, out_data.median_value, want.median_value));
          if (out_data.window_empty !== want.window_empty)
            report_mismatch($sformatf("result %0d window_empty got %0b expected %0b",
                                      results_seen, out_data.window_empty, want.window_empty));
          if (out_data.sample_count !== want.sample_count)
            report_mismatch($sformatf("result %0d sample_count got %0d expected %0d",
                                      results_seen, out_data.sample_count, want.sample_count));
          if (out_data.drop_missing !== want.drop_missing)
            report_mismatch($sformatf("result %0d drop_missing got %0b expected %0b",
                                      results_seen, out_data.drop_missing, want.drop_missing));
          if (out_data.add_overflow !== want.add_overflow)
            report_mismatch($sformatf("result %0d add_overflow got %0b expected %0b",
                                      results_seen, out_data.add_overflow, want.add_overflow));
        end
        results_seen++;
      end
      if (start && !busy) begin
        update_median(in_data, pred);
        expected_results.push_back(pred);
        items_accepted++;
        if (pred.drop_missing) drop_miss_cnt++;
        if (pred.add_overflow) overflow_cnt++;
        if (pred.window_empty) empty_cnt++;
      end
    end
  end

  // Watchdog: no transfer in either direction for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // One input transfer; start drops at the falling edge after acceptance
  task automatic send_item(input hrm_pkg::in_t item);
    if (idle_enable && $urandom_range(0, 99) < 7) repeat ($urandom_range(1, 12)) @(negedge clk);
    @(negedge clk);
    start   <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    start <= 1'b0;
  endtask

  // Build an item and keep the held-sample list in step with it
  task automatic issue(input bit add_v, input logic [7:0] add_s,
                       input bit drop_v, input logic [7:0] drop_s);
    hrm_pkg::in_t item;
    int           idx;
    item.add_valid   = add_v;
    item.add_sample  = add_s;
    item.drop_valid  = drop_v;
    item.drop_sample = drop_s;
    if (drop_v) begin
      idx = -1;
      foreach (window_fifo[k]) if (idx < 0 && window_fifo[k] == drop_s) idx = k;
      if (idx >= 0) window_fifo.delete(idx);
    end
    if (add_v && window_fifo.size() < WINDOW_CAP) window_fifo.push_back(add_s);
    if (window_fifo.size() > peak_window) peak_window = window_fifo.size();
    send_item(item);
  endtask

  // Sample values: edges of the range, a drifting cluster, or uniform
  function automatic logic [7:0] pick_sample();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 10)
      v = ($urandom_range(0, 1) != 0) ? 255 - $urandom_range(0, 3) : $urandom_range(0, 3);
    else if (r < 70)
      v = sample_center + $urandom_range(0, 2 * sample_spread) - sample_spread;
    else
      v = $urandom_range(0, 255);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic test_directed();
    issue(1'b0, 8'hA5, 1'b0, 8'h5A);  // nothing requested on an empty window
    issue(1'b0, 8'h00, 1'b1, 8'h00);  // remove from an empty window
    issue(1'b1, 8'hFF, 1'b1, 8'hFF);  // missing removal, insert at the top bin
    issue(1'b1, 8'h00, 1'b0, 8'hFF);  // long walk back to bin zero
    issue(1'b1, 8'h00, 1'b0, 8'h00);
    issue(1'b1, 8'h80, 1'b1, 8'h00);
    issue(1'b1, 8'hC8, 1'b1, 8'h07);  // missing removal with a good insert
    issue(1'b1, 8'h80, 1'b1, 8'h80);  // remove and insert the same bin
    issue(1'b0, 8'h11, 1'b1, 8'hFF);
    issue(1'b1, 8'hFE, 1'b0, 8'hFF);  // drop field set but not requested
    issue(1'b1, 8'h01, 1'b1, 8'hFE);
    issue(1'b0, 8'hFF, 1'b1, 8'h00);
    issue(1'b0, 8'h00, 1'b1, 8'h01);
    issue(1'b0, 8'h7F, 1'b1, 8'h80);
    issue(1'b0, 8'h00, 1'b1, 8'hC8);  // window empties, pointer left high
    issue(1'b0, 8'hFF, 1'b0, 8'hFF);  // empty window, all field bits set
    issue(1'b1, 8'h10, 1'b0, 8'h00);  // walk back from the stale pointer
    issue(1'b1, 8'hFF, 1'b0, 8'h00);
    issue(1'b1, 8'hFF, 1'b0, 8'h00);
    issue(1'b0, 8'h00, 1'b1, 8'h10);
    issue(1'b1, 8'h00, 1'b1, 8'hFF);
    issue(1'b1, 8'h55, 1'b1, 8'hAA);
  endtask

  // Mostly well-formed window updates with a changing target size
  task automatic test_sliding_window(input int n_items);
    int         target;
    int         r;
    int         idx;
    logic [7:0] v;
    target = 16;
    for (int i = 0; i < n_items; i++) begin
      if (i % 80 == 0) begin
        target        = $urandom_range(0, 80);
        sample_spread = $urandom_range(1, 40);
      end
      // hold off once until the block has drained
      if (i == n_items / 2)
        while (expected_results.size() != 0) @(negedge clk);
      sample_center = sample_center + $urandom_range(0, 6) - 3;
      if (sample_center < 0) sample_center = 0;
      if (sample_center > 255) sample_center = 255;
      r = $urandom_range(0, 99);
      if (r < 10) begin
        issue(1'($urandom_range(0, 1)), rand_byte(), 1'($urandom_range(0, 1)), rand_byte());
      end else if (window_fifo.size() < target) begin
        issue(1'b1, pick_sample(), 1'b0, rand_byte());
      end else if (window_fifo.size() > target) begin
        issue(1'b0, rand_byte(), 1'b1, window_fifo[0]);
      end else if (r < 30 && window_fifo.size() > 0) begin
        idx = $urandom_range(0, window_fifo.size() - 1);
        v   = window_fifo[idx];
        issue(1'b1, pick_sample(), 1'b1, v);
      end else if (window_fifo.size() > 0) begin
        issue(1'b1, pick_sample(), 1'b1, window_fifo[0]);
      end else begin
        issue(1'b1, pick_sample(), 1'b0, rand_byte());
      end
    end
  endtask

  // Fill to the limit without idling, then work at the full window
  task automatic test_capacity(input int n_full);
    int r;
    idle_enable   = 1'b0;
    sample_spread = 24;
    while (window_fifo.size() < WINDOW_CAP) begin
      if ($urandom_range(0, 19) == 0) issue(1'b1, pick_sample(), 1'b1, rand_byte());
      else issue(1'b1, pick_sample(), 1'b0, rand_byte());
    end
    idle_enable = 1'b1;
    for (int i = 0; i < n_full; i++) begin
      r = $urandom_range(0, 3);
      case (r)
        0: begin
          issue(1'b1, pick_sample(), 1'b0, rand_byte());
        end
        1: begin
          issue(1'b1, pick_sample(), 1'b1, window_fifo[0]);
        end
        2: begin
          issue(1'b1, rand_byte(), 1'b1, rand_byte());
        end
        default: begin
          issue(1'b0, rand_byte(), 1'b1, window_fifo[0]);
        end
      endcase
    end
  endtask

  // Unstructured items, every field drawn at random
  task automatic test_noise(input int n_items);
    for (int i = 0; i < n_items; i++)
      issue(1'($urandom_range(0, 1)), rand_byte(), 1'($urandom_range(0, 1)), rand_byte());
  endtask

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_data       = '0;
    idle_enable   = 1'b1;
    sample_center = 128;
    sample_spread = 16;
    error_count   = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_sliding_window(600);
    test_capacity(60);
    test_noise(150);

    while (expected_results.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);

    $display("Ran %0d items through %0d checked results, window up to %0d samples.",
             items_accepted, results_seen, peak_window);
    $display("Seen: %0d ignored removals, %0d refused inserts, %0d empty-window results.",
             drop_miss_cnt, overflow_cnt, empty_cnt);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
